>>> rtl/qpht_pkg.sv
// Shared constants, codes and types of the quadratic probe hash table.
`default_nettype none

package qpht_pkg;

  localparam int unsigned DEF_TABLE_SIZE = 16;
  localparam int unsigned DEF_NAME_CHARS = 8;
  localparam int unsigned MAX_RESULTS    = 16;

  localparam int unsigned NAME_W   = 64;
  localparam int unsigned PHONE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W   = 4;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_INSERTED  = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_FOUND     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } qpht_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_REDUCE,
    ST_PROBE,
    ST_SCAN,
    ST_FINISH
  } qpht_state_e;

endpackage

`default_nettype wire

>>> rtl/qpht_cmpsub.sv
// Shared compare-and-subtract unit: y = (a >= b) ? a - b : a.
`default_nettype none

module qpht_cmpsub #(
  parameter int unsigned W = 18
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic [W-1:0] y_o
);

  assign y_o = (a_i >= b_i) ? (a_i - b_i) : a_i;

endmodule

`default_nettype wire

>>> rtl/qpht_store.sv
// Entry store: valid flops plus name and phone memory with registered read.
`default_nettype none

module qpht_store
  import qpht_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = DEF_TABLE_SIZE,
  parameter int unsigned IW         = $clog2(TABLE_SIZE)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [IW-1:0]      wr_addr_i,
  input  logic [NAME_W-1:0]  wr_name_i,
  input  logic [PHONE_W-1:0] wr_phone_i,
  input  logic [IW-1:0]      probe_addr_i,
  output logic               probe_valid_o,
  input  logic               rd_en_i,
  input  logic [IW-1:0]      rd_addr_i,
  output logic               rd_valid_o,
  output logic [NAME_W-1:0]  rd_name_o,
  output logic [PHONE_W-1:0] rd_phone_o
);

  logic [TABLE_SIZE-1:0] valid_q;
  logic [NAME_W-1:0]     mem_name  [TABLE_SIZE];
  logic [PHONE_W-1:0]    mem_phone [TABLE_SIZE];
  logic                  rd_valid_q;
  logic [NAME_W-1:0]     rd_name_q;
  logic [PHONE_W-1:0]    rd_phone_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_name[wr_addr_i]  <= wr_name_i;
      mem_phone[wr_addr_i] <= wr_phone_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_valid_q <= valid_q[rd_addr_i];
      rd_name_q  <= mem_name[rd_addr_i];
      rd_phone_q <= mem_phone[rd_addr_i];
    end
  end

  assign probe_valid_o = valid_q[probe_addr_i];
  assign rd_valid_o    = rd_valid_q;
  assign rd_name_o     = rd_name_q;
  assign rd_phone_o    = rd_phone_q;

endmodule

`default_nettype wire

>>> rtl/quadratic_probe_hash_table.sv
// Insert: an accept state, a reciprocal-multiply hash state, a reduce state on the shared
// compare-subtract unit, then 1..TABLE_SIZE probes.
// Search: an accept state, then one slot per cycle through the store's read port while no
// held match is waiting on a busy output, then a finish state that waits for the output.
// One item at a time; the next is taken while the last result still waits.
// Reset (async, active low) clears all valid bits at once; no clearing pass.
`default_nettype none

module quadratic_probe_hash_table
  import qpht_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = DEF_TABLE_SIZE,
  parameter int unsigned NAME_CHARS = DEF_NAME_CHARS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                cmd_i,
  input  logic [NAME_W-1:0]   name_bytes_i,
  input  logic [PHONE_W-1:0]  phone_number_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [SLOT_W-1:0]   slot_index_o,
  output logic [PHONE_W-1:0]  phone_out_o,
  output logic                last_o
);

  // widths derived from the table geometry
  localparam int unsigned IW    = $clog2(TABLE_SIZE);
  localparam int unsigned IW1   = IW + 1;
  localparam int unsigned SUM_W = $clog2(NAME_CHARS * 255 + 1);
  localparam int unsigned UW    = SUM_W + IW + 1;
  localparam int unsigned CW    = $clog2(MAX_RESULTS + 1);
  // reciprocal of TABLE_SIZE: exact quotient for every sum below 2**SUM_W
  localparam int unsigned RS    = SUM_W + IW + 1;
  localparam int unsigned RM    = (2**RS + TABLE_SIZE - 1) / TABLE_SIZE;
  localparam int unsigned PW    = SUM_W + RS;

  qpht_state_e state_q, state_d;

  // item registers
  logic [NAME_W-1:0]  name_q, name_d;
  logic [PHONE_W-1:0] phone_q, phone_d;

  // hash reduction: quotient by reciprocal multiply, remainder on the shared unit
  logic [SUM_W-1:0] rem_q, rem_d;
  logic [SUM_W-1:0] quo_q, quo_d;
  logic [PW-1:0]    hash_prod;

  // probe walker: idx = home + k*k, step = 2k+1, both mod TABLE_SIZE
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] step_q, step_d;
  logic [IW-1:0] k_q, k_d;
  logic [IW1-1:0] step_inc;

  // scan pipeline: issue read, then compare in the next cycle
  logic [IW-1:0] ra_q, ra_d;
  logic          issue_done_q, issue_done_d;
  logic          cv_q, cv_d;
  logic [IW-1:0] cidx_q, cidx_d;

  // held match: its last flag is known only once the next match or the end shows
  logic               held_q, held_d;
  logic [IW-1:0]      held_idx_q, held_idx_d;
  logic [PHONE_W-1:0] held_phone_q, held_phone_d;
  logic [CW-1:0]      cnt_q, cnt_d;

  // output register
  logic               out_valid_q, out_valid_d;
  qpht_status_e       out_status_q;
  logic [SLOT_W-1:0]  out_slot_q;
  logic [PHONE_W-1:0] out_phone_q;
  logic               out_last_q;

  logic               emit;
  qpht_status_e       e_status;
  logic [IW-1:0]      e_slot;
  logic [PHONE_W-1:0] e_phone;
  logic               e_last;
  logic [IW+SLOT_W-1:0] e_slot_ext;
  logic               out_free;

  // shared unit
  logic [UW-1:0] unit_a, unit_b, unit_y;

  // store ports
  logic               wr_en;
  logic               probe_valid;
  logic               rd_en;
  logic               rd_valid;
  logic [NAME_W-1:0]  rd_name;
  logic [PHONE_W-1:0] rd_phone;

  logic               cmp_match;

  // name normalization: keep bytes before the first zero byte
  logic [NAME_W-1:0] norm_name;
  logic [SUM_W-1:0]  norm_sum;

  always_comb begin
    logic alive;
    alive     = 1'b1;
    norm_name = '0;
    norm_sum  = '0;
    for (int i = 0; i < NAME_CHARS; i++) begin
      if (name_bytes_i[8*i +: 8] == 8'h00) alive = 1'b0;
      if (alive) begin
        norm_name[8*i +: 8] = name_bytes_i[8*i +: 8];
        norm_sum = norm_sum + SUM_W'(name_bytes_i[8*i +: 8]);
      end
    end
  end

  qpht_cmpsub #(
    .W (UW)
  ) u_unit (
    .a_i (unit_a),
    .b_i (unit_b),
    .y_o (unit_y)
  );

  qpht_store #(
    .TABLE_SIZE (TABLE_SIZE),
    .IW         (IW)
  ) u_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wr_en_i       (wr_en),
    .wr_addr_i     (idx_q),
    .wr_name_i     (name_q),
    .wr_phone_i    (phone_q),
    .probe_addr_i  (idx_q),
    .probe_valid_o (probe_valid),
    .rd_en_i       (rd_en),
    .rd_addr_i     (ra_q),
    .rd_valid_o    (rd_valid),
    .rd_name_o     (rd_name),
    .rd_phone_o    (rd_phone)
  );

  assign out_free  = !out_valid_q || out_ready_i;
  assign cmp_match = cv_q && rd_valid && (rd_name == name_q);
  assign step_inc  = IW1'(step_q) + IW1'(2);
  assign hash_prod = PW'(rem_q) * PW'(RM);

  // sequencer
  always_comb begin
    state_d      = state_q;
    name_d       = name_q;
    phone_d      = phone_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    idx_d        = idx_q;
    step_d       = step_q;
    k_d          = k_q;
    ra_d         = ra_q;
    issue_done_d = issue_done_q;
    cv_d         = cv_q;
    cidx_d       = cidx_q;
    held_d       = held_q;
    held_idx_d   = held_idx_q;
    held_phone_d = held_phone_q;
    cnt_d        = cnt_q;
    emit         = 1'b0;
    e_status     = STAT_NOT_FOUND;
    e_slot       = '0;
    e_phone      = '0;
    e_last       = 1'b1;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    unit_a       = '0;
    unit_b       = '0;
    in_ready_o   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          name_d  = norm_name;
          phone_d = phone_number_i;
          if (cmd_i == CMD_INSERT) begin
            rem_d   = norm_sum;
            state_d = ST_HASH;
          end else begin
            ra_d         = '0;
            issue_done_d = 1'b0;
            cv_d         = 1'b0;
            held_d       = 1'b0;
            cnt_d        = '0;
            state_d      = ST_SCAN;
          end
        end
      end

      ST_HASH: begin
        // quotient of sum / TABLE_SIZE; never exceeds the sum
        quo_d   = hash_prod[RS +: SUM_W];
        state_d = ST_REDUCE;
      end

      ST_REDUCE: begin
        unit_a  = UW'(rem_q);
        unit_b  = UW'(quo_q) * UW'(TABLE_SIZE);
        idx_d   = unit_y[IW-1:0];
        step_d  = IW'(1);
        k_d     = '0;
        state_d = ST_PROBE;
      end

      ST_PROBE: begin
        unit_a = UW'(idx_q) + UW'(step_q);
        unit_b = UW'(TABLE_SIZE);
        if (out_free) begin
          if (!probe_valid) begin
            wr_en    = 1'b1;
            emit     = 1'b1;
            e_status = STAT_INSERTED;
            e_slot   = idx_q;
            state_d  = ST_IDLE;
          end else if (k_q == IW'(TABLE_SIZE - 1)) begin
            emit     = 1'b1;
            e_status = STAT_FULL;
            state_d  = ST_IDLE;
          end else begin
            idx_d = unit_y[IW-1:0];
            k_d   = k_q + 1'b1;
            if (step_inc >= IW1'(TABLE_SIZE)) begin
              step_d = IW'(step_inc - IW1'(TABLE_SIZE));
            end else begin
              step_d = IW'(step_inc);
            end
          end
        end
      end

      ST_SCAN: begin
        // stall only when a held match must leave and the output is busy
        if (!(cmp_match && held_q && !out_free)) begin
          if (!issue_done_q) begin
            rd_en = 1'b1;
            ra_d  = ra_q + 1'b1;
            if (ra_q == IW'(TABLE_SIZE - 1)) issue_done_d = 1'b1;
          end
          cv_d   = !issue_done_q;
          cidx_d = ra_q;
          if (cmp_match) begin
            if (held_q) begin
              emit     = 1'b1;
              e_status = STAT_FOUND;
              e_slot   = held_idx_q;
              e_phone  = held_phone_q;
              e_last   = 1'b0;
            end
            held_d       = 1'b1;
            held_idx_d   = cidx_q;
            held_phone_d = rd_phone;
            cnt_d        = cnt_q + 1'b1;
            if (cnt_q + 1'b1 == CW'(MAX_RESULTS)) state_d = ST_FINISH;
          end else if (issue_done_q && !cv_q) begin
            state_d = ST_FINISH;
          end
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          emit    = 1'b1;
          e_last  = 1'b1;
          state_d = ST_IDLE;
          if (held_q) begin
            e_status = STAT_FOUND;
            e_slot   = held_idx_q;
            e_phone  = held_phone_q;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign e_slot_ext  = {{SLOT_W{1'b0}}, e_slot};
  assign out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      k_q          <= '0;
      ra_q         <= '0;
      issue_done_q <= 1'b0;
      cv_q         <= 1'b0;
      held_q       <= 1'b0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      k_q          <= k_d;
      ra_q         <= ra_d;
      issue_done_q <= issue_done_d;
      cv_q         <= cv_d;
      held_q       <= held_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    name_q       <= name_d;
    phone_q      <= phone_d;
    rem_q        <= rem_d;
    quo_q        <= quo_d;
    idx_q        <= idx_d;
    step_q       <= step_d;
    cidx_q       <= cidx_d;
    held_idx_q   <= held_idx_d;
    held_phone_q <= held_phone_d;
    if (emit) begin
      out_status_q <= e_status;
      out_slot_q   <= e_slot_ext[SLOT_W-1:0];
      out_phone_q  <= e_phone;
      out_last_q   <= e_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign slot_index_o = out_slot_q;
  assign phone_out_o  = out_phone_q;
  assign last_o       = out_last_q;

endmodule

`default_nettype wire

>>> rtl/qpht_checker.sv
// Port-level checks for the quadratic probe hash table, bound to the top.
`default_nettype none

module qpht_props
  import qpht_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [STATUS_W-1:0] status_o,
  input logic [SLOT_W-1:0]   slot_index_o,
  input logic [PHONE_W-1:0]  phone_out_o,
  input logic                last_o
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(slot_index_o) && $stable(phone_out_o) && $stable(last_o))
    else $error("result item changed while stalled");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while item in progress");

  // every status but found ends its item
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STAT_FOUND) |-> last_o)
    else $error("non-found result without last");

  a_phone_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STAT_FOUND) |-> phone_out_o == '0)
    else $error("phone set on non-found result");

  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((status_o == STAT_FULL) || (status_o == STAT_NOT_FOUND))
      |-> slot_index_o == '0)
    else $error("slot set on full or not-found result");

endmodule

bind quadratic_probe_hash_table qpht_props u_qpht_props (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .status_o     (status_o),
  .slot_index_o (slot_index_o),
  .phone_out_o  (phone_out_o),
  .last_o       (last_o)
);

`default_nettype wire

>>> dv/qpht_checker.sv
// Result checker for the quadratic probe hash table: predicts every item and compares.
`default_nettype none

module qpht_checker
  import qpht_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = DEF_TABLE_SIZE,
  parameter int unsigned NAME_CHARS = DEF_NAME_CHARS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic                cmd_i,
  input  logic [NAME_W-1:0]   name_bytes_i,
  input  logic [PHONE_W-1:0]  phone_number_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [STATUS_W-1:0] status_i,
  input  logic [SLOT_W-1:0]   slot_index_i,
  input  logic [PHONE_W-1:0]  phone_out_i,
  input  logic                last_i,
  output int                  errors_o,
  output int                  pending_o,
  output int                  placed_o,
  output int                  full_o,
  output int                  hits_o,
  output int                  misses_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    qpht_status_e         status;
    logic [SLOT_W-1:0]    slot;
    logic [PHONE_W-1:0]   phone;
    logic                 last;
  } dir_result_t;

  dir_result_t due_results[$];
  dir_result_t seen;

  // Shadow copy of the directory.
  logic                 entry_used [TABLE_SIZE];
  logic [NAME_W-1:0]    entry_name [TABLE_SIZE];
  logic [PHONE_W-1:0]   entry_tel  [TABLE_SIZE];

  int errs    = 0;
  int waiting = 0;
  int placed  = 0;
  int fulls   = 0;
  int hits    = 0;
  int misses  = 0;

  assign errors_o  = errs;
  assign pending_o = waiting;
  assign placed_o  = placed;
  assign full_o    = fulls;
  assign hits_o    = hits;
  assign misses_o  = misses;

  // Keep bytes up to the first zero byte; return their unsigned sum too.
  function automatic logic [NAME_W-1:0] trim_name(input logic [NAME_W-1:0] raw,
                                                  output int unsigned sum);
    logic [NAME_W-1:0] kept;
    logic              ended;
    kept  = '0;
    sum   = 0;
    ended = 1'b0;
    for (int i = 0; i < NAME_CHARS && i < 8; i++) begin
      if (raw[8*i +: 8] == 8'h00) ended = 1'b1;
      if (!ended) begin
        kept[8*i +: 8] = raw[8*i +: 8];
        sum += raw[8*i +: 8];
      end
    end
    return kept;
  endfunction

  task automatic lookup_or_place(input logic cmd, input logic [NAME_W-1:0] raw,
                                 input logic [PHONE_W-1:0] tel);
    logic [NAME_W-1:0] key;
    int unsigned       sum;
    int unsigned       home;
    int unsigned       idx;
    int unsigned       found;
    logic              done;
    dir_result_t       r;
    key   = trim_name(raw, sum);
    home  = sum % TABLE_SIZE;
    found = 0;
    done  = 1'b0;
    if (cmd == CMD_INSERT) begin
      for (int unsigned k = 0; k < TABLE_SIZE; k++) begin
        idx = (home + k * k) % TABLE_SIZE;
        if (!done && !entry_used[idx]) begin
          entry_used[idx] = 1'b1;
          entry_name[idx] = key;
          entry_tel[idx]  = tel;
          r = '{status: STAT_INSERTED, slot: idx[SLOT_W-1:0], phone: '0, last: 1'b1};
          due_results.push_back(r);
          done = 1'b1;
        end
      end
      if (!done) begin
        r = '{status: STAT_FULL, slot: '0, phone: '0, last: 1'b1};
        due_results.push_back(r);
      end
    end else begin
      for (int unsigned k = 0; k < TABLE_SIZE; k++) begin
        if (found < MAX_RESULTS && entry_used[k] && entry_name[k] == key) begin
          r = '{status: STAT_FOUND, slot: k[SLOT_W-1:0], phone: entry_tel[k], last: 1'b0};
          due_results.push_back(r);
          found++;
        end
      end
      if (found == 0) begin
        r = '{status: STAT_NOT_FOUND, slot: '0, phone: '0, last: 1'b1};
        due_results.push_back(r);
      end else begin
        due_results[due_results.size() - 1].last = 1'b1;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        entry_used[i] = 1'b0;
        entry_name[i] = '0;
        entry_tel[i]  = '0;
      end
      due_results.delete();
      waiting = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (due_results.size() == 0) begin
          errs++;
          $error("result with nothing expected: status %0d slot %0d phone %0h last %0d",
                 status_i, slot_index_i, phone_out_i, last_i);
        end else begin
          seen = due_results.pop_front();
          if (status_i !== seen.status) begin
            errs++;
            $error("status: expected %0d, actual %0d", seen.status, status_i);
          end
          if (slot_index_i !== seen.slot) begin
            errs++;
            $error("slot_index: expected %0d, actual %0d", seen.slot, slot_index_i);
          end
          if (phone_out_i !== seen.phone) begin
            errs++;
            $error("phone_out: expected %0h, actual %0h", seen.phone, phone_out_i);
          end
          if (last_i !== seen.last) begin
            errs++;
            $error("last: expected %0d, actual %0d", seen.last, last_i);
          end
          case (seen.status)
            STAT_INSERTED: placed++;
            STAT_FULL:     fulls++;
            STAT_FOUND:    hits++;
            default:       misses++;
          endcase
        end
      end
      if (in_valid_i && in_ready_i) begin
        lookup_or_place(cmd_i, name_bytes_i, phone_number_i);
      end
      waiting = due_results.size();
    end
  end

endmodule

`default_nettype wire

>>> dv/quadratic_probe_hash_table_tb.sv
// Testbench top for the quadratic probe hash table: stimulus, back-pressure and verdict.
`default_nettype none

module quadratic_probe_hash_table_tb;
  import qpht_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N_RANDOM    = 295;  // random items after the directed part
  localparam int unsigned QUIET_ITEMS = 40;   // final items sent without any idling
  localparam int unsigned HOLD_AFTER  = 60;   // items sent before the long output stall
  localparam int unsigned HOLD_CYCLES = 250;  // length of that stall
  localparam int unsigned DRAIN_WAIT  = 40;   // longer than the worst item latency without output stalls
  localparam int unsigned POOL_N      = 12;

  // Names used by the directed part.
  localparam logic [NAME_W-1:0] NAME_EMPTY    = 64'h0;
  localparam logic [NAME_W-1:0] NAME_A        = 64'h41;
  localparam logic [NAME_W-1:0] NAME_B        = 64'h42;
  localparam logic [NAME_W-1:0] NAME_ONES     = '1;
  localparam logic [NAME_W-1:0] EMPTY_JUNK    = 64'hFFFF_FFFF_FFFF_FF00;
  localparam logic [NAME_W-1:0] A_JUNK        = 64'hDEAD_BEEF_CAFE_0041;
  localparam logic [NAME_W-1:0] A_JUNK_HIGH   = 64'h8000_0000_0000_0041;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic                cmd_i          = CMD_INSERT;
  logic [NAME_W-1:0]   name_bytes_i   = '0;
  logic [PHONE_W-1:0]  phone_number_i = '0;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [SLOT_W-1:0]   slot_index_o;
  logic [PHONE_W-1:0]  phone_out_o;
  logic                last_o;

  int errors, pending, placed, fulls, hits, misses;

  // Name pool: trimmed names and their lengths. Random items draw from it so
  // searches hit stored entries and inserts collide on the same home slots.
  logic [NAME_W-1:0] pool_name [POOL_N];
  int unsigned       pool_len  [POOL_N];

  int unsigned items_sent = 0;
  bit          quiet_tail = 1'b0;  // no idling on either side in the last part
  bit          hold_done  = 1'b0;

  quadratic_probe_hash_table dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .name_bytes_i   (name_bytes_i),
    .phone_number_i (phone_number_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .slot_index_o   (slot_index_o),
    .phone_out_o    (phone_out_o),
    .last_o         (last_o)
  );

  qpht_checker chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .cmd_i          (cmd_i),
    .name_bytes_i   (name_bytes_i),
    .phone_number_i (phone_number_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_i       (status_o),
    .slot_index_i   (slot_index_o),
    .phone_out_i    (phone_out_o),
    .last_i         (last_o),
    .errors_o       (errors),
    .pending_o      (pending),
    .placed_o       (placed),
    .full_o         (fulls),
    .hits_o         (hits),
    .misses_o       (misses)
  );

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Worst case is far below this: ~310 items, each with its busy time, an input
  // gap and up to 16 results that each wait out an output stall, plus the one
  // long hold. Allow several times over.
  initial begin
    #5_000_000;
    $display("quadratic_probe_hash_table: mismatch");
    $finish;
  end

  // Offer one item. An optional random gap comes first. valid then stays up,
  // payload fixed, until the item is taken. in_ready_o is looked at on the
  // falling edge so the decision never races the rising-edge update.
  task automatic offer_item(input logic cmd, input logic [NAME_W-1:0] name,
                            input logic [PHONE_W-1:0] tel);
    int unsigned gap;
    gap = 0;
    if (!quiet_tail && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 14);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    cmd_i          <= cmd;
    name_bytes_i   <= name;
    phone_number_i <= tel;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    items_sent++;
  endtask

  // Pool name with random garbage above its terminator half of the time when
  // it is under 7 bytes; the block must drop everything after the first zero byte.
  function automatic logic [NAME_W-1:0] pool_pick(input int unsigned idx);
    logic [NAME_W-1:0] junk;
    junk = {$urandom, $urandom};
    if (pool_len[idx] < 7 && $urandom_range(0, 1) == 1)
      return pool_name[idx] | (junk << (8 * (pool_len[idx] + 1)));
    return pool_name[idx];
  endfunction

  // Receiver: mostly ready, random stall bursts, one long hold once the
  // sender is well under way so the block backs up and stops taking items.
  initial begin
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        out_ready_i <= 1'b0;
      end else if (!hold_done && items_sent >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    logic [NAME_W-1:0]  nm;
    logic               cmd;
    int unsigned        len;

    // Pool: empty name, "A", the all-ones name, then random names of 1..8
    // nonzero bytes.
    pool_name[0] = NAME_EMPTY; pool_len[0] = 0;
    pool_name[1] = NAME_A;     pool_len[1] = 1;
    pool_name[2] = NAME_ONES;  pool_len[2] = 8;
    for (int p = 3; p < POOL_N; p++) begin
      len = $urandom_range(1, 8);
      nm  = '0;
      for (int b = 0; b < len; b++) nm[8*b +: 8] = 8'($urandom_range(1, 255));
      pool_name[p] = nm;
      pool_len[p]  = len;
    end

    // Hold reset, then release it on a rising edge.
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part.
    offer_item(CMD_SEARCH, NAME_EMPTY, 32'h0);           // empty table: not found
    offer_item(CMD_INSERT, NAME_EMPTY, 32'h0);           // empty name goes to slot 0
    offer_item(CMD_SEARCH, NAME_EMPTY, '1);              // phone ignored on search
    offer_item(CMD_SEARCH, EMPTY_JUNK, 32'h1234_5678);   // leading zero byte = empty name
    offer_item(CMD_INSERT, NAME_ONES, '1);               // full-length name, max phone
    offer_item(CMD_SEARCH, NAME_ONES, 32'h0);
    // Same name five times: home slot, then +1, +4, +9, then table full
    // (k*k mod 16 only ever reaches four distinct offsets).
    offer_item(CMD_INSERT, A_JUNK, 32'h0000_0001);
    offer_item(CMD_INSERT, NAME_A, 32'h8000_0000);
    offer_item(CMD_INSERT, A_JUNK_HIGH, 32'h5555_5555);
    offer_item(CMD_INSERT, NAME_A, 32'hAAAA_AAAA);
    offer_item(CMD_INSERT, A_JUNK, 32'hFFFF_0000);
    offer_item(CMD_SEARCH, A_JUNK_HIGH, 32'h0);          // duplicates: several results
    offer_item(CMD_SEARCH, NAME_B, 32'h0);               // miss
    offer_item(CMD_INSERT, NAME_B, 32'h0BAD_F00D);       // home 2 taken, probes onward
    offer_item(CMD_SEARCH, NAME_B, 32'h0);
    offer_item(CMD_SEARCH, {$urandom, $urandom}, $urandom);

    // Random part: mostly pool names so entries pile up on shared probe
    // chains, the rest raw 64-bit noise.
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n >= N_RANDOM - QUIET_ITEMS) quiet_tail = 1'b1;
      cmd = ($urandom_range(0, 99) < 35) ? CMD_INSERT : CMD_SEARCH;
      if ($urandom_range(0, 9) < 8) nm = pool_pick($urandom_range(0, POOL_N - 1));
      else nm = {$urandom, $urandom};
      offer_item(cmd, nm, $urandom);
    end
    in_valid_i <= 1'b0;

    // Drain, then give the block time to emit anything stray.
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("covered %0d items: %0d inserts placed, %0d table full, %0d found, %0d not found",
             items_sent, placed, fulls, hits, misses);
    $display("output held off for %0d cycles once with the input side backed up",
             HOLD_CYCLES);
    if (errors == 0 && pending == 0) begin
      $display("quadratic_probe_hash_table: match");
    end else begin
      $display("quadratic_probe_hash_table: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
